### src/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, muted while in reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, but also checked during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/sboa_pkg.sv
package sboa_pkg;

  // Default geometry
  localparam int OBJECTS_IN_SLAB_DEF = 512;
  localparam int SLABS_PER_CLASS_DEF = 4;
  localparam int SIZE_CLASSES_DEF    = 8;

  // Smallest object in bytes
  localparam int MIN_OBJECT = 32;

  // Command codes
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ZERO     = 3'd1;
  localparam logic [2:0] ST_NO_CLASS = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd4;

endpackage

### src/slab_bitmap_object_allocator_core.sv
// Size-classed slab allocator. Each request (allocate, free, query) yields one result.
// Object use bits live in a 64-bit-wide synchronous memory, one word per 64 objects,
// and per-slab free counts in a second small memory; both are read, changed and
// written back one request at a time; no new request is taken until the last result
// is handed on. A free or query steps through accept, decode, check and result;
// a rejected request skips the check. An allocate reads the count of each slab of
// its class in turn to select a slab, then scans at most ceil(OBJECTS_IN_SLAB/64)
// bitmap words from the first; it ends at selection if each slab of the class is full.
// No clearing pass is needed after reset: a valid flag per bitmap word, and the slab
// active bits for the counts, stand in for it.
// A finished result waits in the output register while the next request is taken.
`include "assert_macros.svh"

module slab_bitmap_object_allocator_core #(
  parameter int OBJECTS_IN_SLAB = sboa_pkg::OBJECTS_IN_SLAB_DEF,
  parameter int SLABS_PER_CLASS = sboa_pkg::SLABS_PER_CLASS_DEF,
  parameter int SIZE_CLASSES    = sboa_pkg::SIZE_CLASSES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_request_size,
  input  logic [2:0]  in_obj_class,
  input  logic [1:0]  in_obj_slab,
  input  logic [8:0]  in_obj_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [2:0]  out_got_class,
  output logic [1:0]  out_got_slab,
  output logic [8:0]  out_got_index,
  output logic [12:0] out_object_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_classes_present
);

  localparam int SLAB_TOTAL = SIZE_CLASSES * SLABS_PER_CLASS;
  localparam int SW   = (SLAB_TOTAL > 1) ? $clog2(SLAB_TOTAL) : 1;
  localparam int WORDS = (OBJECTS_IN_SLAB + 63) / 64;
  localparam int WW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BM_DEPTH = SLAB_TOTAL * WORDS;
  localparam int BAW  = (BM_DEPTH > 1) ? $clog2(BM_DEPTH) : 1;
  localparam int IW   = $clog2(OBJECTS_IN_SLAB);
  localparam int CW   = $clog2(OBJECTS_IN_SLAB + 1);
  localparam int JW   = (SLABS_PER_CLASS > 1) ? $clog2(SLABS_PER_CLASS) : 1;
  localparam int CLW  = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
  localparam int LAST_BITS = OBJECTS_IN_SLAB - (WORDS - 1) * 64;
  localparam logic [63:0] LAST_MASK = {64{1'b1}} >> (64 - LAST_BITS);
  localparam logic [CW-1:0] FULL_CNT = CW'(OBJECTS_IN_SLAB);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DEC  = 9'b000000010,
    S_SRD  = 9'b000000100,
    S_SEV  = 9'b000001000,
    S_PICK = 9'b000010000,
    S_WRD  = 9'b000100000,
    S_WEV  = 9'b001000000,
    S_CHK  = 9'b010000000,
    S_RES  = 9'b100000000
  } state_t;

  // Bitmap word address of a slab and word
  function automatic logic [BAW-1:0] bm_addr(input logic [SW-1:0] s, input logic [WW-1:0] w);
    bm_addr = BAW'(s) * BAW'(WORDS) + BAW'(w);
  endfunction

  state_t state_r, state_nxt;

  // Request fields
  logic [1:0]  cmd_r;
  logic [15:0] size_r;
  logic [2:0]  cls_r;
  logic [1:0]  sl_r;
  logic [8:0]  ix_r;

  // Working registers
  logic [CLW-1:0] k_r, k_nxt;
  logic [SW-1:0]  base_r, base_nxt;
  logic [JW-1:0]  j_r, j_nxt;
  logic           have_part_r, have_part_nxt, have_emp_r, have_emp_nxt;
  logic           have_in_r, have_in_nxt;
  logic [JW-1:0]  part_j_r, part_j_nxt, emp_j_r, emp_j_nxt, in_j_r, in_j_nxt;
  logic [CW-1:0]  part_cnt_r, part_cnt_nxt;
  logic [SW-1:0]  s_r, s_nxt;
  logic [JW-1:0]  pick_r, pick_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [WW-1:0]  w_r, w_nxt;
  logic [SLAB_TOTAL-1:0] active_r, active_nxt;
  logic [BM_DEPTH-1:0]   bm_valid_r, bm_valid_nxt;
  logic [7:0] cfg_r;

  // Pending result
  logic [2:0]  res_status_r, res_status_nxt;
  logic [2:0]  res_class_r, res_class_nxt;
  logic [1:0]  res_slab_r, res_slab_nxt;
  logic [8:0]  res_index_r, res_index_nxt;
  logic [12:0] res_bytes_r, res_bytes_nxt;

  // Output register
  logic        out_valid_r;
  logic [2:0]  out_status_r, out_class_r;
  logic [1:0]  out_slab_r;
  logic [8:0]  out_index_r;
  logic [12:0] out_bytes_r;

  // Memories
  logic [63:0]   bm_mem [BM_DEPTH];
  logic [CW-1:0] fc_mem [SLAB_TOTAL];
  logic [BAW-1:0] bm_raddr;
  logic [SW-1:0]  fc_raddr;
  logic [63:0]   bm_rd_r, bm_wdata;
  logic          bm_rv_r, bm_we;
  logic [CW-1:0] fc_rd_r, fc_wdata;
  logic          fc_rv_r, fc_we;

  // Decode helpers
  logic [21:0] need;
  logic [4:0]  kk;
  logic        cls_ok;
  logic [IW-1:0] ix_idx;
  logic [SW-1:0] s_calc;
  logic [WW-1:0] w_calc;
  logic          held_ok;
  logic [63:0]   word, free_bits, mask;
  logic [5:0]    pos;
  logic          act;
  logic [CW-1:0] cnt;
  logic          out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  // Rounded size to class: smallest k with 32 << k >= size + 1
  always_comb begin
    need = 22'(size_r) + 22'd1;
    kk = 5'd16;
    for (int q = 16; q >= 0; q--) begin
      if ((22'(sboa_pkg::MIN_OBJECT) << q) >= need) kk = 5'(q);
    end
    cls_ok = (kk < 5'(SIZE_CLASSES)) && (kk <= 5'd7) && cfg_r[kk[2:0]];
  end

  // Handle decode for free and query
  always_comb begin
    ix_idx  = IW'(ix_r);
    s_calc  = SW'(cls_r) * SW'(SLABS_PER_CLASS) + SW'(sl_r);
    w_calc  = WW'(ix_idx >> 6);
    held_ok = (32'(cls_r) < 32'(SIZE_CLASSES)) && (32'(sl_r) < 32'(SLABS_PER_CLASS)) &&
              (32'(ix_r) < 32'(OBJECTS_IN_SLAB));
  end

  // Lowest free object in the word just read
  always_comb begin
    word = bm_rv_r ? bm_rd_r : 64'd0;
    mask = (32'(w_r) == 32'(WORDS - 1)) ? LAST_MASK : {64{1'b1}};
    free_bits = ~word & mask;
    pos = 6'd0;
    for (int i = 63; i >= 0; i--) begin
      if (free_bits[i]) pos = 6'(i);
    end
    act = active_r[fc_raddr];
    cnt = fc_rv_r ? fc_rd_r : FULL_CNT;
  end

  // Memory read addresses
  always_comb begin
    bm_raddr = (state_r == S_DEC) ? bm_addr(s_calc, w_calc) : bm_addr(s_r, w_r);
    fc_raddr = (state_r == S_DEC) ? s_calc : (base_r + SW'(j_r));
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    k_nxt = k_r; base_nxt = base_r; j_nxt = j_r;
    have_part_nxt = have_part_r; have_emp_nxt = have_emp_r; have_in_nxt = have_in_r;
    part_j_nxt = part_j_r; emp_j_nxt = emp_j_r; in_j_nxt = in_j_r;
    part_cnt_nxt = part_cnt_r;
    s_nxt = s_r; pick_nxt = pick_r; cnt_nxt = cnt_r; w_nxt = w_r;
    active_nxt = active_r; bm_valid_nxt = bm_valid_r;
    res_status_nxt = res_status_r; res_class_nxt = res_class_r; res_slab_nxt = res_slab_r;
    res_index_nxt = res_index_r; res_bytes_nxt = res_bytes_r;
    bm_we = 1'b0; bm_wdata = word;
    fc_we = 1'b0; fc_wdata = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DEC;
      end
      S_DEC: begin
        res_status_nxt = sboa_pkg::ST_OK;
        res_class_nxt = 3'd0; res_slab_nxt = 2'd0; res_index_nxt = 9'd0;
        res_bytes_nxt = 13'd0;
        priority if (cmd_r == sboa_pkg::CMD_ALLOC) begin
          k_nxt = CLW'(kk);
          base_nxt = SW'(kk) * SW'(SLABS_PER_CLASS);
          j_nxt = '0;
          have_part_nxt = 1'b0; have_emp_nxt = 1'b0; have_in_nxt = 1'b0;
          if (size_r == 16'd0) begin
            res_status_nxt = sboa_pkg::ST_ZERO;
            state_nxt = S_RES;
          end else if (!cls_ok) begin
            res_status_nxt = sboa_pkg::ST_NO_CLASS;
            state_nxt = S_RES;
          end else begin
            state_nxt = S_SRD;
          end
        end else if (cmd_r == sboa_pkg::CMD_FREE || cmd_r == sboa_pkg::CMD_QUERY) begin
          s_nxt = s_calc;
          w_nxt = w_calc;
          if (held_ok) begin
            state_nxt = S_CHK;
          end else begin
            res_status_nxt = sboa_pkg::ST_NOT_ALLOC;
            state_nxt = S_RES;
          end
        end else begin
          res_status_nxt = sboa_pkg::ST_NO_CLASS;
          state_nxt = S_RES;
        end
      end
      S_SRD: begin
        state_nxt = S_SEV;
      end
      // Note the first partly used, empty and inactive slab of the class; full slabs are passed over
      S_SEV: begin
        if (act && cnt != '0 && cnt != FULL_CNT && !have_part_r) begin
          have_part_nxt = 1'b1; part_j_nxt = j_r; part_cnt_nxt = cnt;
        end
        if (act && cnt == FULL_CNT && !have_emp_r) begin
          have_emp_nxt = 1'b1; emp_j_nxt = j_r;
        end
        if (!act && !have_in_r) begin
          have_in_nxt = 1'b1; in_j_nxt = j_r;
        end
        if (32'(j_r) == 32'(SLABS_PER_CLASS - 1)) begin
          state_nxt = S_PICK;
        end else begin
          j_nxt = j_r + JW'(1);
          state_nxt = S_SRD;
        end
      end
      S_PICK: begin
        priority if (have_part_r) begin
          pick_nxt = part_j_r; cnt_nxt = part_cnt_r;
        end else if (have_emp_r) begin
          pick_nxt = emp_j_r; cnt_nxt = FULL_CNT;
        end else begin
          pick_nxt = in_j_r; cnt_nxt = FULL_CNT;
        end
        if (have_part_r || have_emp_r || have_in_r) begin
          s_nxt = base_r + SW'(pick_nxt);
          active_nxt[s_nxt] = 1'b1;
          w_nxt = '0;
          state_nxt = S_WRD;
        end else begin
          res_status_nxt = sboa_pkg::ST_FULL;
          state_nxt = S_RES;
        end
      end
      S_WRD: begin
        state_nxt = S_WEV;
      end
      // Take the lowest free bit, else move to the next word, or report full after the last word
      S_WEV: begin
        if (free_bits != 64'd0) begin
          bm_we = 1'b1;
          bm_wdata = word | (64'd1 << pos);
          bm_valid_nxt[bm_addr(s_r, w_r)] = 1'b1;
          fc_we = 1'b1;
          fc_wdata = (cnt_r != '0) ? (cnt_r - CW'(1)) : cnt_r;
          res_class_nxt = 3'(k_r);
          res_slab_nxt = 2'(pick_r);
          res_index_nxt = 9'((IW'(w_r) << 6) | IW'(pos));
          res_bytes_nxt = 13'(sboa_pkg::MIN_OBJECT) << k_r;
          state_nxt = S_RES;
        end else if (32'(w_r) == 32'(WORDS - 1)) begin
          res_status_nxt = sboa_pkg::ST_FULL;
          state_nxt = S_RES;
        end else begin
          w_nxt = w_r + WW'(1);
          state_nxt = S_WRD;
        end
      end
      // Free or query of a checked handle
      S_CHK: begin
        if (!(active_r[s_r] && word[ix_idx[5:0]])) begin
          res_status_nxt = sboa_pkg::ST_NOT_ALLOC;
        end else if (cmd_r == sboa_pkg::CMD_QUERY) begin
          res_bytes_nxt = 13'(sboa_pkg::MIN_OBJECT) << cls_r;
        end else begin
          bm_we = 1'b1;
          bm_wdata = word & ~(64'd1 << ix_idx[5:0]);
          bm_valid_nxt[bm_addr(s_r, w_r)] = 1'b1;
          fc_we = 1'b1;
          fc_wdata = (cnt < FULL_CNT) ? (cnt + CW'(1)) : cnt;
        end
        state_nxt = S_RES;
      end
      S_RES: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memories: one write and one registered read each; a count is valid once its
  // slab is active, since activation always writes the count
  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_addr(s_r, w_r)] <= bm_wdata;
    bm_rd_r <= bm_mem[bm_raddr];
    bm_rv_r <= bm_valid_r[bm_raddr];
    if (fc_we) fc_mem[s_r] <= fc_wdata;
    fc_rd_r <= fc_mem[fc_raddr];
    fc_rv_r <= active_r[fc_raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      active_r <= '0;
      bm_valid_r <= '0;
      cfg_r <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      active_r <= active_nxt;
      bm_valid_r <= bm_valid_nxt;
      if (cfg_valid && cfg_ready) cfg_r <= cfg_classes_present;
      if (state_r == S_RES && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r <= in_cmd;
      size_r <= in_request_size;
      cls_r <= in_obj_class;
      sl_r <= in_obj_slab;
      ix_r <= in_obj_index;
    end
    k_r <= k_nxt; base_r <= base_nxt; j_r <= j_nxt;
    have_part_r <= have_part_nxt; have_emp_r <= have_emp_nxt; have_in_r <= have_in_nxt;
    part_j_r <= part_j_nxt; emp_j_r <= emp_j_nxt; in_j_r <= in_j_nxt;
    part_cnt_r <= part_cnt_nxt;
    s_r <= s_nxt; pick_r <= pick_nxt; cnt_r <= cnt_nxt; w_r <= w_nxt;
    res_status_r <= res_status_nxt; res_class_r <= res_class_nxt;
    res_slab_r <= res_slab_nxt; res_index_r <= res_index_nxt; res_bytes_r <= res_bytes_nxt;
    if (state_r == S_RES && out_free) begin
      out_status_r <= res_status_r;
      out_class_r <= res_class_r;
      out_slab_r <= res_slab_r;
      out_index_r <= res_index_r;
      out_bytes_r <= res_bytes_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_got_class    = out_class_r;
  assign out_got_slab     = out_slab_r;
  assign out_got_index    = out_index_r;
  assign out_object_bytes = out_bytes_r;

  // A finished result holds until the output slot frees up
  `ASSERT_CLK(a_res_waits, (state_r == S_RES && out_valid_r && out_stall) |=> (state_r == S_RES), "result left before output slot was free")
  // Failed requests carry no handle and no size
  `ASSERT_CLK(a_fail_clean, (out_valid && out_status != sboa_pkg::ST_OK) |-> (out_object_bytes == 13'd0 && out_got_index == 9'd0), "failed request carries data")
  // Slabs never go inactive
  `ASSERT_CLK(a_active_sticky, (($past(active_r) & ~active_r) == '0), "slab lost its active bit")

endmodule
